@@ hdl/lfgd_pkg.sv @@
package lfgd_pkg;

  localparam int DistW   = 32;
  localparam int RegW    = 31;
  localparam int HeightW = 32;
  localparam int IdxW    = 10;
  localparam int AddrW   = 5;

  localparam logic [2:0] REG_STEP_I  = 3'd0;
  localparam logic [2:0] REG_STEP_J  = 3'd1;
  localparam logic [2:0] REG_BASE    = 3'd2;
  localparam logic [2:0] REG_HEAVE   = 3'd3;
  localparam logic [2:0] REG_DETACH  = 3'd4;
  localparam logic [2:0] REG_DECAY   = 3'd5;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [5:0]  SHIFT_LIM = 6'd17;

  // 2^(-k/16) in Q.16, k = 0..16
  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/lfgd_node_if.sv @@
interface lfgd_node_if;
  import lfgd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [IdxW-1:0]    column_index;
  logic        [IdxW-1:0]    row_index;
  logic signed [HeightW-1:0] height_in;
  modport source (output valid, column_index, row_index, height_in, input ready);
  modport sink   (input valid, column_index, row_index, height_in, output ready);
endinterface

@@ hdl/lfgd_result_if.sv @@
interface lfgd_result_if;
  import lfgd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [HeightW-1:0] height_out;
  logic                      in_hanging_wall;
  logic                      saturated;
  modport source (output valid, height_out, in_hanging_wall, saturated, input ready);
  modport sink   (input valid, height_out, in_hanging_wall, saturated, output ready);
endinterface

@@ hdl/lfgd_depth.sv @@
// D*(1 - exp(-r*x)), five register stages, advances when en is high.
module lfgd_depth #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [lfgd_pkg::RegW-1:0] x,
  input  logic [lfgd_pkg::RegW-1:0] rate,
  input  logic [lfgd_pkg::RegW-1:0] depth_max,
  output logic [31:0]          depth
);
  import lfgd_pkg::*;

  localparam int Sh = 2 * FRAC_BITS - 16;

  logic [2*RegW-1:0] prod;
  logic [2*RegW-1:0] t;
  logic [37:0]       u_full;
  logic [21:0]       u;
  logic              big;
  logic [5:0]        n_c;
  logic [16:0]       a_c;
  logic [16:0]       b_c;
  logic [11:0]       diff_c;
  logic [23:0]       lerp_c;
  logic [5:0]        n;
  logic [16:0]       a;
  logic [23:0]       lerp;
  logic              zero;
  logic [16:0]       m;
  logic [16:0]       e;
  logic [47:0]       dprod;

  assign t      = prod >> Sh;
  assign u_full = t[20:0] * LOG2E_Q16;
  assign n_c    = u[21:16];
  assign a_c    = pow2_neg({1'b0, u[15:12]});
  assign b_c    = pow2_neg({1'b0, u[15:12]} + 5'd1);
  // adjacent table entries differ by less than 4096
  assign diff_c = 12'(a_c - b_c);
  assign lerp_c = diff_c * u[11:0];
  assign m      = a - {5'd0, lerp[23:12]};
  assign depth  = dprod[47:16];

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= x * rate;
      big   <= |t[2*RegW-1:21];
      u     <= u_full[37:16];
      zero  <= big || (n_c >= SHIFT_LIM);
      n     <= n_c;
      a     <= a_c;
      lerp  <= lerp_c;
      e     <= zero ? 17'd0 : (m >> n);
      dprod <= depth_max * (17'd65536 - e);
    end
  end
endmodule

@@ hdl/listric_fault_grid_displace.sv @@
// Listric normal-fault displacement of grid nodes.
// node_in carries one grid node per word (column, row, height in Q16.16);
// node_out returns one word per node: new height, hanging-wall flag and
// a saturation flag. Both are valid/ready channels; a word moves when
// valid and ready are high at a rising edge.
// Registers are written over the APB port (4-byte stride); the user must
// do so only while idle, as the block itself does not enforce it.
// Throughput is one node per cycle while node_out takes words, set by the
// eight-stage pipeline (index products, distance and clamp, five depth
// stages for r*x, exp lookup, interpolation, depth product, then output).
// When node_out stalls the whole pipeline holds; node_in.ready is low
// while the output stage holds a word that node_out does not take.
// Nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads register defaults.
module listric_fault_grid_displace #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  lfgd_node_if.sink                node_in,
  lfgd_result_if.source            node_out,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [lfgd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import lfgd_pkg::*;

  localparam int Depth = 8;

  logic signed [31:0] step_i, step_j, dist_base;
  logic [RegW-1:0]    heave, depth_cap, decay_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_i     <= 32'sd655360;
      step_j     <= 32'sd0;
      dist_base  <= 32'sd0;
      heave      <= '0;
      depth_cap  <= 31'd65536;
      decay_rate <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_STEP_I: step_i     <= pwdata;
        REG_STEP_J: step_j     <= pwdata;
        REG_BASE:   dist_base  <= pwdata;
        REG_HEAVE:  heave      <= pwdata[RegW-1:0];
        REG_DETACH: depth_cap  <= pwdata[RegW-1:0];
        REG_DECAY:  decay_rate <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      REG_STEP_I: prdata = step_i;
      REG_STEP_J: prdata = step_j;
      REG_BASE:   prdata = dist_base;
      REG_HEAVE:  prdata = {1'b0, heave};
      REG_DETACH: prdata = {1'b0, depth_cap};
      REG_DECAY:  prdata = {1'b0, decay_rate};
      default:    prdata = 32'd0;
    endcase
  end

  logic [Depth-1:0] vld;
  logic             en;
  assign en            = !vld[Depth-1] || node_out.ready;
  assign node_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], node_in.valid};
  end

  // stage 1: index products
  logic signed [42:0] p_i, p_j;
  logic signed [31:0] h1;
  always_ff @(posedge clk) begin
    if (en) begin
      p_i <= $signed({1'b0, node_in.column_index}) * step_i;
      p_j <= $signed({1'b0, node_in.row_index}) * step_j;
      h1  <= node_in.height_in;
    end
  end

  // stage 2: distance, clamp, offset past heave
  logic signed [44:0] dsum;
  logic signed [31:0] d_c;
  logic               dsat_c;
  logic signed [32:0] off0;
  assign dsum = 45'(dist_base) + 45'(p_i) + 45'(p_j);
  always_comb begin
    dsat_c = 1'b0;
    if (dsum > 45'sd2147483647) begin
      d_c = 32'sh7fffffff; dsat_c = 1'b1;
    end else if (dsum < -45'sd2147483648) begin
      d_c = 32'sh80000000; dsat_c = 1'b1;
    end else begin
      d_c = dsum[31:0];
    end
  end
  assign off0 = 33'(d_c) - $signed({2'b00, heave});

  logic [RegW-1:0] x_fd, x_d0;
  logic            hw2, sat2, pos2;
  logic signed [31:0] h2;
  always_ff @(posedge clk) begin
    if (en) begin
      x_fd <= d_c[RegW-1:0];
      x_d0 <= off0[RegW-1:0];
      pos2 <= off0 > 33'sd0;
      hw2  <= !d_c[31];
      sat2 <= dsat_c;
      h2   <= h1;
    end
  end

  logic [31:0] fd, dep0;
  lfgd_depth #(.FRAC_BITS(FRAC_BITS)) u_fd (
    .clk(clk), .en(en), .x(x_fd), .rate(decay_rate),
    .depth_max(depth_cap), .depth(fd));
  lfgd_depth #(.FRAC_BITS(FRAC_BITS)) u_d0 (
    .clk(clk), .en(en), .x(x_d0), .rate(decay_rate),
    .depth_max(depth_cap), .depth(dep0));

  // side info rides alongside the five depth stages
  logic signed [31:0] h_d  [5];
  logic [4:0]         hw_d, sat_d, pos_d;
  always_ff @(posedge clk) begin
    if (en) begin
      h_d[0] <= h2;
      for (int s = 1; s < 5; s++) h_d[s] <= h_d[s-1];
      hw_d  <= {hw_d[3:0], hw2};
      sat_d <= {sat_d[3:0], sat2};
      pos_d <= {pos_d[3:0], pos2};
    end
  end

  // output stage
  logic signed [34:0] hsum;
  logic signed [31:0] h_c;
  logic               hsat_c;
  assign hsum = 35'(h_d[4]) + (pos_d[4] ? $signed({3'b000, dep0}) : 35'sd0)
              - $signed({3'b000, fd});
  always_comb begin
    hsat_c = 1'b0;
    if (!hw_d[4]) begin
      h_c = h_d[4];
    end else if (hsum > 35'sd2147483647) begin
      h_c = 32'sh7fffffff; hsat_c = 1'b1;
    end else if (hsum < -35'sd2147483648) begin
      h_c = 32'sh80000000; hsat_c = 1'b1;
    end else begin
      h_c = hsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      node_out.height_out      <= h_c;
      node_out.in_hanging_wall <= hw_d[4];
      node_out.saturated       <= sat_d[4] || hsat_c;
    end
  end
  assign node_out.valid = vld[Depth-1];
endmodule
